>>> sv/qrbr_pkg.sv
// ----------------------------------------------------------------------------
// QR band rasterizer package
// Field widths, register reset values, register indexes and the sequencer
// states shared by the band rasterizer.
// ----------------------------------------------------------------------------
package qrbr_pkg;

  localparam int unsigned MaxModulesDef = 32;

  localparam int unsigned SizeW    = 6;
  localparam int unsigned QuietW   = 4;
  localparam int unsigned DotsW    = 16;
  localparam int unsigned ModW     = 7;
  localparam int unsigned BandW    = 13;
  localparam int unsigned BandCntW = 14;
  localparam int unsigned RowIdxW  = 5;
  localparam int unsigned RowBitsW = 32;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned DivCntW  = 4;
  localparam int unsigned BitCntW  = 3;

  localparam logic [SizeW-1:0]   SizeRst     = 6'd21;
  localparam logic [QuietW-1:0]  QuietRst    = 4'd4;
  localparam logic [DotsW-1:0]   ReservedRst = 16'd0;
  localparam logic [QuietW-1:0]  QuietMax    = 4'd8;

  // Dots per band is eight, so band arithmetic is a shift by three.
  localparam int unsigned        BandShift   = 3;
  localparam logic [ByteW-1:0]   TopDot      = 8'h80;
  localparam logic [BitCntW-1:0] LastDot     = 3'd7;
  localparam logic [DivCntW-1:0] DivLast     = 4'd15;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MATRIX_SIZE   = 2'd0,
    CFG_QUIET_ZONE    = 2'd1,
    CFG_RESERVED_DOTS = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    REQ_LOAD   = 1'b0,
    REQ_COLUMN = 1'b1
  } req_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_SCALE,
    ST_GEOM,
    ST_CHECK,
    ST_DIV_CX,
    ST_DIV_CY,
    ST_ROW_RD,
    ST_ROW_EV,
    ST_DONE
  } state_e;

endpackage

>>> sv/qr_module_band_rasterizer_top.sv
// ----------------------------------------------------------------------------
// QR module band rasterizer
// Holds a QR module matrix and turns it into 8-dot column bytes for a
// bit-image printer, with a quiet-zone border and a fitted integer scale.
// ----------------------------------------------------------------------------
// Usage: configure matrix size, quiet zone and reserved height through the
// write port while the block is idle. Then send beats on the input channel:
// a load beat writes one matrix row, a column beat asks for the column byte
// at (band, column). Every input beat yields exactly one output beat, which
// also carries scale, side, band count, fits flag and padding feed.
// The block handles one item at a time. A load runs the scale division,
// the geometry step and the row write before its output is valid. A
// column request inside the code makes three passes of the shared
// restoring divider (scale, module column, first module row) and then a
// registered row-store read and an evaluation step for each dot. A column
// request outside the code or with no fitting scale skips the later passes.
// Reset restores the default registers; the row store keeps no reset and
// must be loaded before it is read. A stalled receiver holds the result in
// the output register; the next item is accepted meanwhile and its result
// waits until the previous beat is taken.
module qr_module_band_rasterizer_top #(
  parameter int unsigned MAX_MODULES = qrbr_pkg::MaxModulesDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,

  input  logic                           cfg_we_i,
  input  logic [qrbr_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [qrbr_pkg::DotsW-1:0]     cfg_wdata_i,

  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           in_req_type_i,
  input  logic [qrbr_pkg::RowIdxW-1:0]   in_row_index_i,
  input  logic [qrbr_pkg::RowBitsW-1:0]  in_row_bits_i,
  input  logic [qrbr_pkg::BandW-1:0]     in_band_index_i,
  input  logic [qrbr_pkg::DotsW-1:0]     in_column_index_i,

  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [qrbr_pkg::ByteW-1:0]     out_column_byte_o,
  output logic [qrbr_pkg::DotsW-1:0]     out_scale_o,
  output logic [qrbr_pkg::DotsW-1:0]     out_side_dots_o,
  output logic [qrbr_pkg::BandCntW-1:0]  out_band_count_o,
  output logic                           out_fits_o,
  output logic [qrbr_pkg::DotsW-1:0]     out_pad_dots_o
);
  import qrbr_pkg::*;

  localparam int unsigned AddrW = $clog2(MAX_MODULES);

  state_e state_q, state_d;

  logic [SizeW-1:0]    cfg_size_q;
  logic [QuietW-1:0]   cfg_quiet_q;
  logic [DotsW-1:0]    cfg_resv_q;

  logic                req_q, req_d;
  logic [RowIdxW-1:0]  row_q, row_d;
  logic [RowBitsW-1:0] bits_q, bits_d;
  logic [BandW-1:0]    band_q, band_d;
  logic [DotsW-1:0]    x_q, x_d;

  logic [DotsW-1:0]    rem_q, rem_d;
  logic [DotsW-1:0]    quo_q, quo_d;
  logic [DivCntW-1:0]  cnt_q, cnt_d;

  logic [DotsW-1:0]    scale_q, scale_d;
  logic [DotsW-1:0]    side_q, side_d;
  logic [BandCntW-1:0] bands_q, bands_d;
  logic [DotsW-1:0]    pad_q, pad_d;
  logic [ModW-1:0]     cx_q, cx_d;
  logic [ModW-1:0]     cy_q, cy_d;
  logic [DotsW-1:0]    r_q, r_d;
  logic [DotsW-1:0]    y_q, y_d;
  logic [BitCntW-1:0]  bit_q, bit_d;
  logic [ByteW-1:0]    col_q, col_d;

  logic                out_valid_q, out_valid_d;
  logic [ByteW-1:0]    out_col_q, out_col_d;
  logic [DotsW-1:0]    out_scale_q, out_scale_d;
  logic [DotsW-1:0]    out_side_q, out_side_d;
  logic [BandCntW-1:0] out_bands_q, out_bands_d;
  logic [DotsW-1:0]    out_pad_q, out_pad_d;

  logic [RowBitsW-1:0] mem_q [MAX_MODULES];
  logic [RowBitsW-1:0] rd_data_q;
  logic [AddrW-1:0]    rd_addr;
  logic                mem_we;

  // Effective geometry from the configuration registers.
  logic [ModW-1:0]     size_eff;
  logic [QuietW-1:0]   quiet_eff;
  logic [ModW-1:0]     quiet_ext;
  logic [ModW-1:0]     modules;

  always_comb begin
    if (cfg_size_q == '0) begin
      size_eff = ModW'(1);
    end else if (cfg_size_q > MAX_MODULES) begin
      size_eff = ModW'(MAX_MODULES);
    end else begin
      size_eff = ModW'(cfg_size_q);
    end
  end

  assign quiet_eff = (cfg_quiet_q > QuietMax) ? QuietMax : cfg_quiet_q;
  assign quiet_ext = ModW'(quiet_eff);
  assign modules   = size_eff + {quiet_ext[ModW-2:0], 1'b0};

  // Shared restoring divider, one quotient bit per cycle.
  logic [DotsW-1:0]    div_den;
  logic [DotsW:0]      rem_sh;
  logic [DotsW:0]      div_diff;
  logic                div_take;
  logic [DotsW-1:0]    rem_nx;
  logic [DotsW-1:0]    quo_nx;
  logic                div_last;

  assign div_den  = (state_q == ST_DIV_SCALE) ? DotsW'(modules) : scale_q;
  assign rem_sh   = {rem_q, quo_q[DotsW-1]};
  assign div_diff = rem_sh - {1'b0, div_den};
  assign div_take = ~div_diff[DotsW];
  assign rem_nx   = div_take ? div_diff[DotsW-1:0] : rem_sh[DotsW-1:0];
  assign quo_nx   = {quo_q[DotsW-2:0], div_take};
  assign div_last = (cnt_q == DivLast);

  // Geometry derived from the scale.
  logic [ModW+DotsW-1:0] side_prod;
  logic [DotsW:0]        side_p7;
  logic [BandCntW-1:0]   bands_c;
  logic [DotsW-1:0]      pad_c;
  logic                  row_ok;
  logic                  col_go;

  assign side_prod = modules * scale_q;
  assign side_p7   = {1'b0, side_q} + (DotsW+1)'(7);
  assign bands_c   = side_p7[DotsW:BandShift];
  assign pad_c     = (scale_q != '0) ? cfg_resv_q - {bands_c[BandCntW-2:0], 3'b000}
                                     : cfg_resv_q;
  assign row_ok    = (row_q < MAX_MODULES);
  assign col_go    = (req_q == REQ_COLUMN) && (scale_q != '0) &&
                     (BandCntW'(band_q) < bands_c) && (x_q < side_q);

  // Dot evaluation for the current vertical position.
  logic [ModW-1:0]  mx;
  logic [ModW-1:0]  my;
  logic             my_ok;
  logic             dot_dark;
  logic [DotsW:0]   r_inc;

  assign mx    = cx_q - quiet_ext;
  assign my    = cy_q - quiet_ext;
  assign my_ok = (my < MAX_MODULES);
  assign rd_addr = my_ok ? AddrW'(my) : '0;
  assign dot_dark = (y_q < side_q) && (cx_q >= quiet_ext) && (cy_q >= quiet_ext) &&
                    (mx < size_eff) && (my < size_eff) && (mx < ModW'(RowBitsW)) &&
                    my_ok && rd_data_q[mx[RowIdxW-1:0]];
  assign r_inc = {1'b0, r_q} + (DotsW+1)'(1);

  assign mem_we = (state_q == ST_CHECK) && (req_q == REQ_LOAD) && row_ok;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_size_q  <= SizeRst;
      cfg_quiet_q <= QuietRst;
      cfg_resv_q  <= ReservedRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MATRIX_SIZE:   cfg_size_q  <= cfg_wdata_i[SizeW-1:0];
        CFG_QUIET_ZONE:    cfg_quiet_q <= cfg_wdata_i[QuietW-1:0];
        CFG_RESERVED_DOTS: cfg_resv_q  <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // Row store.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[AddrW'(row_q)] <= bits_q;
    end
    rd_data_q <= mem_q[rd_addr];
  end

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:      if (in_valid_i) state_d = ST_DIV_SCALE;
      ST_DIV_SCALE: if (div_last) state_d = ST_GEOM;
      ST_GEOM:      state_d = ST_CHECK;
      ST_CHECK:     state_d = col_go ? ST_DIV_CX : ST_DONE;
      ST_DIV_CX:    if (div_last) state_d = ST_DIV_CY;
      ST_DIV_CY:    if (div_last) state_d = ST_ROW_RD;
      ST_ROW_RD:    state_d = ST_ROW_EV;
      // The module row may change after each dot, so read it again.
      ST_ROW_EV:    state_d = (bit_q == LastDot) ? ST_DONE : ST_ROW_RD;
      ST_DONE:      if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready_o = (state_q == ST_IDLE);
  end

  // Datapath.
  always_comb begin
    req_d   = req_q;
    row_d   = row_q;
    bits_d  = bits_q;
    band_d  = band_q;
    x_d     = x_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    cnt_d   = cnt_q;
    scale_d = scale_q;
    side_d  = side_q;
    bands_d = bands_q;
    pad_d   = pad_q;
    cx_d    = cx_q;
    cy_d    = cy_q;
    r_d     = r_q;
    y_d     = y_q;
    bit_d   = bit_q;
    col_d   = col_q;

    out_valid_d = out_valid_q;
    out_col_d   = out_col_q;
    out_scale_d = out_scale_q;
    out_side_d  = out_side_q;
    out_bands_d = out_bands_q;
    out_pad_d   = out_pad_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          req_d  = in_req_type_i;
          row_d  = in_row_index_i;
          bits_d = in_row_bits_i;
          band_d = in_band_index_i;
          x_d    = in_column_index_i;
          rem_d  = '0;
          quo_d  = {cfg_resv_q[DotsW-1:BandShift], 3'b000};
          cnt_d  = '0;
        end
      end
      ST_DIV_SCALE: begin
        rem_d = rem_nx;
        quo_d = quo_nx;
        cnt_d = cnt_q + DivCntW'(1);
        if (div_last) begin
          scale_d = quo_nx;
        end
      end
      ST_GEOM: begin
        side_d = side_prod[DotsW-1:0];
      end
      ST_CHECK: begin
        bands_d = bands_c;
        pad_d   = pad_c;
        col_d   = '0;
        bit_d   = '0;
        y_d     = {band_q, 3'b000};
        rem_d   = '0;
        quo_d   = x_q;
        cnt_d   = '0;
      end
      ST_DIV_CX: begin
        rem_d = rem_nx;
        quo_d = quo_nx;
        cnt_d = cnt_q + DivCntW'(1);
        if (div_last) begin
          cx_d  = quo_nx[ModW-1:0];
          rem_d = '0;
          quo_d = y_q;
        end
      end
      ST_DIV_CY: begin
        rem_d = rem_nx;
        quo_d = quo_nx;
        cnt_d = cnt_q + DivCntW'(1);
        if (div_last) begin
          cy_d = quo_nx[ModW-1:0];
          r_d  = rem_nx;
        end
      end
      ST_ROW_EV: begin
        if (dot_dark) begin
          col_d = col_q | (TopDot >> bit_q);
        end
        y_d   = y_q + DotsW'(1);
        bit_d = bit_q + BitCntW'(1);
        // Step the remainder instead of dividing again for each dot row.
        if (r_inc == {1'b0, scale_q}) begin
          r_d  = '0;
          cy_d = cy_q + ModW'(1);
        end else begin
          r_d = r_inc[DotsW-1:0];
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_col_d   = col_q;
          out_scale_d = scale_q;
          out_side_d  = side_q;
          out_bands_d = bands_q;
          out_pad_d   = pad_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q       <= req_d;
    row_q       <= row_d;
    bits_q      <= bits_d;
    band_q      <= band_d;
    x_q         <= x_d;
    rem_q       <= rem_d;
    quo_q       <= quo_d;
    cnt_q       <= cnt_d;
    scale_q     <= scale_d;
    side_q      <= side_d;
    bands_q     <= bands_d;
    pad_q       <= pad_d;
    cx_q        <= cx_d;
    cy_q        <= cy_d;
    r_q         <= r_d;
    y_q         <= y_d;
    bit_q       <= bit_d;
    col_q       <= col_d;
    out_col_q   <= out_col_d;
    out_scale_q <= out_scale_d;
    out_side_q  <= out_side_d;
    out_bands_q <= out_bands_d;
    out_pad_q   <= out_pad_d;
  end

  assign out_valid_o       = out_valid_q;
  assign out_column_byte_o = out_col_q;
  assign out_scale_o       = out_scale_q;
  assign out_side_dots_o   = out_side_q;
  assign out_band_count_o  = out_bands_q;
  assign out_fits_o        = (out_scale_q != '0);
  assign out_pad_dots_o    = out_pad_q;

  // The divider remainder always stays below the divisor in use.
  a_div_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV_SCALE || state_q == ST_DIV_CX || state_q == ST_DIV_CY)
      |-> (rem_q < div_den))
    else $error("divider remainder reached the divisor");

  // An accepted beat keeps the block busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("block ready right after accepting a beat");

  // A code that does not fit prints nothing and has no bands.
  a_no_fit_blank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_fits_o)
      |-> (out_column_byte_o == '0 && out_side_dots_o == '0 && out_band_count_o == '0))
    else $error("non-fitting result carries dots or bands");

  // The bands cover the side with less than one band to spare.
  a_band_cover: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_fits_o)
      |-> (({out_band_count_o, 3'b000} >= {1'b0, out_side_dots_o}) &&
           ({out_band_count_o, 3'b000} < ({1'b0, out_side_dots_o} + 17'd8))))
    else $error("band count does not match side length");

endmodule

>>> verif/qr_module_band_rasterizer_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// QR band rasterizer testbench
// Preloads the whole module matrix, then runs a short directed set per
// register setting followed by random phases. Every accepted beat is
// predicted in the bench, and each output beat is compared field by field
// with the oldest prediction while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module qr_module_band_rasterizer_top_test;
  import qrbr_pkg::*;

  localparam int unsigned CycleLimit    = 1000000;
  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned SettleCycles  = 80;
  localparam int unsigned RandomPhases  = 12;
  localparam int unsigned PhaseBeats    = 115;

  typedef struct packed {
    req_e                req;
    logic [RowIdxW-1:0]  row_index;
    logic [RowBitsW-1:0] row_bits;
    logic [BandW-1:0]    band;
    logic [DotsW-1:0]    column;
  } raster_req_t;

  typedef struct packed {
    logic [ByteW-1:0]    column_byte;
    logic [DotsW-1:0]    scale;
    logic [DotsW-1:0]    side_dots;
    logic [BandCntW-1:0] band_count;
    logic                fits;
    logic [DotsW-1:0]    pad_dots;
  } raster_result_t;

  typedef struct packed {
    int unsigned size;
    int unsigned quiet;
    int unsigned scale;
    int unsigned side;
    int unsigned bands;
    int unsigned pad;
  } fit_t;

  logic                clk_i             = 1'b0;
  logic                rst_ni            = 1'b0;
  logic                cfg_we_i          = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i         = '0;
  logic [DotsW-1:0]    cfg_wdata_i       = '0;
  logic                in_valid_i        = 1'b0;
  logic                in_ready_o;
  logic                in_req_type_i     = 1'b0;
  logic [RowIdxW-1:0]  in_row_index_i    = '0;
  logic [RowBitsW-1:0] in_row_bits_i     = '0;
  logic [BandW-1:0]    in_band_index_i   = '0;
  logic [DotsW-1:0]    in_column_index_i = '0;
  logic                out_valid_o;
  logic                out_ready_i       = 1'b0;
  logic [ByteW-1:0]    out_column_byte_o;
  logic [DotsW-1:0]    out_scale_o;
  logic [DotsW-1:0]    out_side_dots_o;
  logic [BandCntW-1:0] out_band_count_o;
  logic                out_fits_o;
  logic [DotsW-1:0]    out_pad_dots_o;

  qr_module_band_rasterizer_top dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .in_req_type_i     (in_req_type_i),
    .in_row_index_i    (in_row_index_i),
    .in_row_bits_i     (in_row_bits_i),
    .in_band_index_i   (in_band_index_i),
    .in_column_index_i (in_column_index_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .out_column_byte_o (out_column_byte_o),
    .out_scale_o       (out_scale_o),
    .out_side_dots_o   (out_side_dots_o),
    .out_band_count_o  (out_band_count_o),
    .out_fits_o        (out_fits_o),
    .out_pad_dots_o    (out_pad_dots_o)
  );

  // Bench copy of the block's registers and row store.
  logic [SizeW-1:0]    set_size     = SizeRst;
  logic [QuietW-1:0]   set_quiet    = QuietRst;
  logic [DotsW-1:0]    set_reserved = ReservedRst;
  logic [RowBitsW-1:0] module_rows [MaxModulesDef];

  raster_req_t    pending_beats [$];
  raster_result_t expected_results [$];
  raster_req_t    offered_beat;
  raster_result_t due_result;

  int unsigned outstanding      = 0;
  int unsigned error_count      = 0;
  int unsigned cycle_count      = 0;
  int unsigned send_gap         = 0;
  int unsigned ready_stall      = 0;
  int unsigned loads_sent       = 0;
  int unsigned columns_sent     = 0;
  int unsigned dark_bytes       = 0;
  int unsigned no_fit_results   = 0;
  int unsigned settings_applied = 0;
  bit          sending;
  bit          sender_idling    = 1'b0;
  bit          receiver_idling  = 1'b0;
  bit          hold_off_req     = 1'b0;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CycleLimit);
    $display("tb: failure");
    $finish;
  end

  // Mostly back to back, now and then a short gap, rarely a long one.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic fit_t fit_geometry();
    fit_t        fit;
    int unsigned modules;
    int unsigned reserved;
    reserved  = 32'(set_reserved);
    fit.size  = (set_size == '0) ? 32'd1 : 32'(set_size);
    if (fit.size > MaxModulesDef) fit.size = MaxModulesDef;
    fit.quiet = (set_quiet > QuietMax) ? 32'(QuietMax) : 32'(set_quiet);
    modules   = fit.size + 2 * fit.quiet;
    // Rounding the reservation down to whole bands gives the largest
    // scale whose rounded-up band height still fits.
    fit.scale = ((reserved >> BandShift) << BandShift) / modules;
    fit.side  = modules * fit.scale;
    fit.bands = (fit.side + 7) >> BandShift;
    fit.pad   = (fit.scale != 0) ? reserved - (fit.bands << BandShift) : reserved;
    return fit;
  endfunction

  function automatic raster_result_t rasterize_beat(raster_req_t beat);
    fit_t           fit;
    raster_result_t res;
    int unsigned    cx;
    int unsigned    cy;
    int unsigned    y;
    fit = fit_geometry();
    res.column_byte = '0;
    if (beat.req == REQ_LOAD) begin
      module_rows[beat.row_index] = beat.row_bits;
    end else if (fit.scale != 0 && beat.band < fit.bands && beat.column < fit.side) begin
      cx = beat.column / fit.scale;
      for (int dot = 0; dot < 8; dot++) begin
        y = (int'(beat.band) << BandShift) + dot;
        if (y < fit.side) begin
          cy = y / fit.scale;
          if (cx >= fit.quiet && cy >= fit.quiet && cx - fit.quiet < fit.size &&
              cy - fit.quiet < fit.size && module_rows[cy - fit.quiet][cx - fit.quiet]) begin
            res.column_byte |= TopDot >> dot;
          end
        end
      end
    end
    res.scale      = DotsW'(fit.scale);
    res.side_dots  = DotsW'(fit.side);
    res.band_count = BandCntW'(fit.bands);
    res.fits       = (fit.scale != 0);
    res.pad_dots   = DotsW'(fit.pad);
    return res;
  endfunction

  // Unused fields carry random junk; the block must ignore them.
  function automatic raster_req_t make_load(int unsigned row, logic [RowBitsW-1:0] bits);
    raster_req_t beat;
    beat.req       = REQ_LOAD;
    beat.row_index = RowIdxW'(row);
    beat.row_bits  = bits;
    beat.band      = BandW'($urandom());
    beat.column    = DotsW'($urandom());
    return beat;
  endfunction

  function automatic raster_req_t make_column(int unsigned band, int unsigned x);
    raster_req_t beat;
    beat.req       = REQ_COLUMN;
    beat.row_index = RowIdxW'($urandom());
    beat.row_bits  = RowBitsW'($urandom());
    beat.band      = BandW'(band);
    beat.column    = DotsW'(x);
    return beat;
  endfunction

  function automatic raster_req_t random_beat();
    fit_t        fit;
    int unsigned pick;
    fit  = fit_geometry();
    pick = $urandom_range(0, 99);
    if (pick < 12) return make_load($urandom_range(0, 31), $urandom());
    if (pick < 85 && fit.scale != 0) begin
      return make_column($urandom_range(0, fit.bands - 1), $urandom_range(0, fit.side - 1));
    end
    if (pick < 88) return make_column(fit.bands + $urandom_range(0, 1),
                                      $urandom_range(0, fit.side));
    if (pick < 92 && fit.bands != 0) begin
      return make_column($urandom_range(0, fit.bands - 1), fit.side + $urandom_range(0, 2));
    end
    return make_column($urandom(), $urandom());
  endfunction

  task automatic queue_beat(raster_req_t beat);
    pending_beats.push_back(beat);
    outstanding++;
    if (beat.req == REQ_LOAD) loads_sent++;
    else columns_sent++;
  endtask

  task automatic wait_drained();
    while (outstanding != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [DotsW-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    case (idx)
      CFG_MATRIX_SIZE:   set_size     = data[SizeW-1:0];
      CFG_QUIET_ZONE:    set_quiet    = data[QuietW-1:0];
      CFG_RESERVED_DOTS: set_reserved = data;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Upper bits above each register's width are junk and must be dropped.
  task automatic apply_setting(logic [SizeW-1:0] size, logic [QuietW-1:0] quiet,
                               logic [DotsW-1:0] reserved);
    logic [DotsW-1:0] junk;
    junk = DotsW'($urandom());
    write_reg(CFG_MATRIX_SIZE, {junk[DotsW-1:SizeW], size});
    write_reg(CFG_QUIET_ZONE, {junk[DotsW-1:QuietW], quiet});
    write_reg(CFG_RESERVED_DOTS, reserved);
    settings_applied++;
  endtask

  task automatic random_setting();
    logic [SizeW-1:0]  size;
    logic [QuietW-1:0] quiet;
    logic [DotsW-1:0]  reserved;
    case ($urandom_range(0, 5))
      0: size = '0;
      1: size = SizeW'(MaxModulesDef);
      2: size = SizeW'($urandom_range(MaxModulesDef + 1, 63));
      default: size = SizeW'($urandom_range(1, MaxModulesDef));
    endcase
    case ($urandom_range(0, 5))
      0: quiet = '0;
      1: quiet = QuietMax;
      2: quiet = QuietW'($urandom_range(9, 15));
      default: quiet = QuietW'($urandom_range(0, 8));
    endcase
    case ($urandom_range(0, 9))
      0, 1, 2, 3: reserved = DotsW'($urandom_range(0, 700));
      4, 5, 6: reserved = DotsW'($urandom());
      7: reserved = '1;
      default: reserved = DotsW'($urandom_range(0, 15));
    endcase
    apply_setting(size, quiet, reserved);
  endtask

  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      error_count++;
    end
  endtask

  // Sender: offers the next queued beat once the current one is taken.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      sending = in_valid_i;
      if (in_valid_i && in_ready_o) begin
        due_result = rasterize_beat(offered_beat);
        expected_results.push_back(due_result);
        if (due_result.column_byte != '0) dark_bytes++;
        if (!due_result.fits) no_fit_results++;
        sending = 1'b0;
      end
      if (!sending) begin
        if (send_gap != 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_beats.size() != 0) begin
          offered_beat = pending_beats.pop_front();
          in_valid_i        <= 1'b1;
          in_req_type_i     <= offered_beat.req;
          in_row_index_i    <= offered_beat.row_index;
          in_row_bits_i     <= offered_beat.row_bits;
          in_band_index_i   <= offered_beat.band;
          in_column_index_i <= offered_beat.column;
          send_gap = sender_idling ? pick_gap() : 0;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each taken beat and throttles ready.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $error("output beat arrived with no request outstanding");
          error_count++;
        end else begin
          due_result = expected_results.pop_front();
          outstanding--;
          compare_field("column_byte", 32'(due_result.column_byte), 32'(out_column_byte_o));
          compare_field("scale", 32'(due_result.scale), 32'(out_scale_o));
          compare_field("side_dots", 32'(due_result.side_dots), 32'(out_side_dots_o));
          compare_field("band_count", 32'(due_result.band_count), 32'(out_band_count_o));
          compare_field("fits", 32'(due_result.fits), 32'(out_fits_o));
          compare_field("pad_dots", 32'(due_result.pad_dots), 32'(out_pad_dots_o));
        end
      end
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        ready_stall  = HoldOffCycles;
      end
      if (ready_stall != 0) begin
        ready_stall--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if (receiver_idling && $urandom_range(0, 3) == 0) ready_stall = pick_gap();
      end
    end
  end

  initial begin
    bit stall_phase;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    sender_idling   = 1'b1;
    receiver_idling = 1'b1;

    // Fill every row first so no column request can touch an unloaded row.
    // This runs on the reset registers, where nothing fits.
    for (int r = 0; r < MaxModulesDef; r++) begin
      queue_beat(make_load(r, (r == 0) ? '1 : (r == 1) ? '0 : RowBitsW'($urandom())));
    end
    wait_drained();

    // Scale 3 with a partial last band.
    apply_setting(6'd21, 4'd4, 16'd90);
    queue_beat(make_load(0, '1));
    queue_beat(make_load(20, 32'h8000_0001));
    queue_beat(make_load(31, '0));
    queue_beat(make_column(0, 0));
    queue_beat(make_column(1, 12));
    queue_beat(make_column(10, 86));
    queue_beat(make_column(11, 0));
    queue_beat(make_column(0, 87));
    queue_beat(make_column(8191, 65535));
    queue_beat(make_load(5, 32'h0010_0010));
    queue_beat(make_column(3, 24));
    wait_drained();

    // A zero size acts as one module, which gives the largest scale.
    apply_setting(6'd0, 4'd0, 16'hFFFF);
    queue_beat(make_column(0, 0));
    queue_beat(make_column(8190, 65527));
    queue_beat(make_column(8191, 0));
    queue_beat(make_column(0, 65528));
    queue_beat(make_load(0, '0));
    wait_drained();

    // Oversized size and quiet zone saturate, and seven dots cannot fit.
    apply_setting(6'd63, 4'd15, 16'd7);
    queue_beat(make_column(0, 0));
    queue_beat(make_load(3, 32'hA5A5_5A5A));
    queue_beat(make_column(2, 5));
    wait_drained();

    apply_setting(6'd32, 4'd8, 16'hFFFF);
    queue_beat(make_column(1365, 10920));
    queue_beat(make_column(6654, 53235));
    queue_beat(make_column(8189, 65519));
    queue_beat(make_column(8190, 0));
    wait_drained();

    for (int p = 0; p < RandomPhases; p++) begin
      random_setting();
      stall_phase     = (p == 1 || p == 7);
      sender_idling   = !stall_phase && (p % 3 != 0);
      receiver_idling = (p % 4 != 2);
      repeat (PhaseBeats) queue_beat(random_beat());
      // A long receiver hold-off while the sender keeps offering fills the
      // block and backs up its input.
      if (stall_phase) hold_off_req = 1'b1;
      wait_drained();
    end

    repeat (SettleCycles) @(posedge clk_i);
    $display("Covered %0d row loads and %0d column requests over %0d register settings.",
             loads_sent, columns_sent, settings_applied);
    $display("Saw %0d non-blank column bytes and %0d beats where the code did not fit.",
             dark_bytes, no_fit_results);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/qrbr_pkg.sv
sv/qr_module_band_rasterizer_top.sv
verif/qr_module_band_rasterizer_top_test.sv
